// ----- sv/hvn_pkg.sv -----
package hvn_pkg;

    localparam int MAX_GRID_DEF = 1024;

    localparam int GS_W = 11;
    localparam logic [GS_W-1:0] GS_RESET = 11'd64;

    localparam int H_W = 16;
    localparam int D_W = H_W + 1;

    // Shared rounding divider: signed numerator, unsigned denominator.
    localparam int NUM_W = 54;
    localparam int DEN_W = 33;
    localparam int QB    = 26;
    localparam int Q_W   = QB + 1;

    // Shared integer square root.
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;

    // Signed difference of two unsigned heights.
    function automatic logic signed [D_W-1:0] hdiff(input logic [H_W-1:0] a,
                                                    input logic [H_W-1:0] b);
        logic signed [D_W-1:0] sa;
        logic signed [D_W-1:0] sb;
        sa = signed'({1'b0, a});
        sb = signed'({1'b0, b});
        return sa - sb;
    endfunction

endpackage

// ----- sv/hvn_mem.sv -----
module hvn_mem #(
    parameter int ADDR_W = 11
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic [hvn_pkg::H_W-1:0]    i_wr_data,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    output logic [hvn_pkg::H_W-1:0]    o_rd_data
);

    logic [hvn_pkg::H_W-1:0] mem [2**ADDR_W];
    logic [hvn_pkg::H_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/hvn_isqrt.sv -----
module hvn_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hvn_pkg::RAD_W-1:0]     i_rad,
    output logic                          o_done,
    output logic [hvn_pkg::ROOT_W-1:0]    o_root
);

    localparam int W = hvn_pkg::RAD_W;

    logic         r_busy;
    logic         r_done;
    logic [W-1:0] r_v;
    logic [W-1:0] r_res;
    logic [W-1:0] r_bit;
    logic [W-1:0] w_sum;

    // One result bit per cycle, bit position walking down two at a time.
    assign w_sum = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && r_bit[0];
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_rad;
            r_res <= '0;
            r_bit <= W'(1) << (W - 2);
        end else if (r_busy) begin
            if (r_v >= w_sum) begin
                r_v   <= r_v - w_sum;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[hvn_pkg::ROOT_W-1:0];

endmodule

// ----- sv/hvn_div.sv -----
module hvn_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [hvn_pkg::NUM_W-1:0]    i_num,
    input  logic [hvn_pkg::DEN_W-1:0]           i_den,
    output logic                                o_done,
    output logic signed [hvn_pkg::Q_W-1:0]      o_quot
);

    localparam int N_W = hvn_pkg::NUM_W + 1;
    localparam int R_W = hvn_pkg::DEN_W + 1;
    localparam int QB  = hvn_pkg::QB;
    localparam int C_W = $clog2(QB + 1);

    logic           r_busy;
    logic           r_done;
    logic           r_neg;
    logic [C_W-1:0] r_cnt;
    logic [R_W-1:0] r_rem;
    logic [R_W-1:0] r_d;
    logic [QB-1:0]  r_low;
    logic [QB-1:0]  r_q;

    logic [hvn_pkg::NUM_W-1:0] w_mag;
    logic [N_W-1:0]            w_n;
    logic [R_W:0]              w_t;
    logic                      w_ge;

    // Rounded quotient with halves away from zero: (2|num| + den) / (2 den).
    // The quotient is known to fit QB bits, so the top of the dividend
    // starts out already below the divisor.
    assign w_mag = i_num[hvn_pkg::NUM_W-1] ? hvn_pkg::NUM_W'(-i_num)
                                           : hvn_pkg::NUM_W'(i_num);
    assign w_n   = (N_W'(w_mag) << 1) + N_W'(i_den);
    assign w_t   = {r_rem, r_low[QB-1]};
    assign w_ge  = w_t >= (R_W+1)'(r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == C_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == C_W'(1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[hvn_pkg::NUM_W-1];
            r_rem <= R_W'(w_n[N_W-1:QB]);
            r_low <= w_n[QB-1:0];
            r_d   <= {i_den, 1'b0};
            r_q   <= '0;
            r_cnt <= C_W'(QB);
        end else if (r_busy) begin
            r_rem <= w_ge ? R_W'(w_t - (R_W+1)'(r_d)) : R_W'(w_t);
            r_low <= r_low << 1;
            r_q   <= {r_q[QB-2:0], w_ge};
            r_cnt <= r_cnt - C_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -signed'({1'b0, r_q}) : signed'({1'b0, r_q});

endmodule

// ----- sv/heightmap_vertex_normals.sv -----
// Vertex normals of a square heightmap, one normal per sample, one row behind.
// Heights enter on the s_axis channel row by row: grid_size rows of grid_size
// samples, then one padding row whose heights are ignored. Each request from
// the second row on yields one normal on m_axis for the vertex one row above
// it; tlast marks the final vertex of the grid. Requests of the first row
// yield nothing. The config channel writes grid_size and restarts the grid.
// Each normal sums the unit normals of up to six adjacent triangles and is
// renormalized; all roots and divisions run on one bit-serial square root
// unit and one bit-serial rounding divider. One item is worked on at a
// time: no new height is taken until the current one is finished.
// A finished normal waits in the output register while the next height is
// taken; if the receiver still stalls when that next normal is done, the
// block holds it and accepts nothing more until the register frees.
// Reset is synchronous: grid_size returns to 64, counters to zero, no output.
module heightmap_vertex_normals #(
    parameter int MAX_GRID = hvn_pkg::MAX_GRID_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [15:0] height
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // [15:0] normal_x, [30:16] normal_y,
                                       // [46:31] normal_z, [47] zero
    output logic        m_axis_tlast,  // last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data     // grid_size
);

    localparam int COL_W  = $clog2(MAX_GRID);
    localparam int ROW_W  = $clog2(MAX_GRID + 1);
    localparam int ADDR_W = COL_W + 1;
    localparam int H_W    = hvn_pkg::H_W;
    localparam int D_W    = hvn_pkg::D_W;
    localparam int NUM_W  = hvn_pkg::NUM_W;
    localparam int DEN_W  = hvn_pkg::DEN_W;
    localparam int Q_W    = hvn_pkg::Q_W;
    localparam int S_W    = 28;
    localparam int P_W    = 2 * S_W;
    localparam int A_W    = hvn_pkg::RAD_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_READ  = 4'd1;
    localparam logic [3:0] ST_TRI   = 4'd2;
    localparam logic [3:0] ST_SQ    = 4'd3;
    localparam logic [3:0] ST_ROOT  = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_SUM   = 4'd6;
    localparam logic [3:0] ST_ROOT2 = 4'd7;
    localparam logic [3:0] ST_NDIV  = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    localparam logic [2:0] LAST_TRI = 3'd5;

    function automatic logic signed [15:0] clamp_s(input logic signed [Q_W-1:0] q);
        if (q < -Q_W'(16384)) begin
            return -16'sd16384;
        end else if (q > Q_W'(16384)) begin
            return 16'sd16384;
        end
        return 16'(q);
    endfunction

    function automatic logic [14:0] clamp_y(input logic signed [Q_W-1:0] q);
        if (q < Q_W'(0)) begin
            return 15'd0;
        end else if (q > Q_W'(16384)) begin
            return 15'd16384;
        end
        return 15'(q);
    endfunction

    // Configuration and grid position.
    logic [hvn_pkg::GS_W-1:0] r_gs;
    logic [COL_W-1:0]         r_col, n_col;
    logic [ROW_W-1:0]         r_row, n_row;
    logic [ROW_W-1:0]         w_n;
    logic [ROW_W-1:0]         w_col_inc;

    // Sequencer.
    logic [3:0] r_state, n_state;
    logic [2:0] r_k, n_k;
    logic [2:0] r_t, n_t;

    // Item in progress: position flags and the gathered neighborhood.
    logic             r_up, r_dn, r_lf, r_rt, r_emit, r_last, r_slot;
    logic [COL_W-1:0] r_j;
    logic [H_W-1:0]   r_cur, r_h0, r_hl, r_hr, r_hu, r_hur, r_hdl;

    // Arithmetic state.
    logic signed [D_W-1:0]   r_x, r_z, n_x, n_z;
    logic [A_W-1:0]          r_acc, n_acc;
    logic [A_W-1:0]          r_rad, n_rad;
    logic [hvn_pkg::ROOT_W-1:0] r_root, n_root;
    logic signed [NUM_W-1:0] r_dnum, n_dnum;
    logic signed [S_W-1:0]   r_sx, r_sy, r_sz, n_sx, n_sy, n_sz;
    logic signed [15:0]      r_nx, r_nz, n_nx, n_nz;
    logic [14:0]             r_ny, n_ny;
    logic                    r_go_root, n_go_root, r_go_div, n_go_div;

    // Output register.
    logic               r_ovalid, n_ovalid;
    logic signed [15:0] r_onx, r_onz;
    logic [14:0]        r_ony;
    logic               r_olast;
    logic               w_load;

    logic                    w_in_acc;
    logic [ADDR_W-1:0]       w_rd_addr;
    logic [H_W-1:0]          w_rd_data;
    logic                    w_wr_en;
    logic                    w_tri_en;
    logic signed [D_W-1:0]   w_tx, w_tz;
    logic signed [S_W-1:0]   w_mul_a;
    logic [P_W-1:0]          w_prod;
    logic                    w_root_done, w_div_done;
    logic [hvn_pkg::ROOT_W-1:0] w_root;
    logic signed [Q_W-1:0]   w_q;
    logic signed [S_W-1:0]   w_qs;

    // Sizes outside the supported range are taken as the nearest bound.
    always_comb begin
        if (r_gs < hvn_pkg::GS_W'(2)) begin
            w_n = ROW_W'(2);
        end else if (32'(r_gs) > MAX_GRID) begin
            w_n = ROW_W'(MAX_GRID);
        end else begin
            w_n = ROW_W'(r_gs);
        end
    end

    assign w_col_inc     = ROW_W'(r_col) + ROW_W'(1);
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign s_axis_tready = (r_state == ST_IDLE) && !i_cfg_valid;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // Next grid position after the accepted height; a config write restarts it.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cfg_valid && o_cfg_ready) begin
            n_col = '0;
            n_row = '0;
        end else if (w_in_acc) begin
            if (w_col_inc >= w_n) begin
                n_col = '0;
                n_row = (r_row == w_n) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = COL_W'(w_col_inc);
            end
        end
    end

    // The two row slots alternate by row parity: the slot of the current row
    // still holds the row two above until this item overwrites its column.
    always_comb begin
        case (r_k)
            3'd0:    w_rd_addr = {~r_slot, r_j};
            3'd1:    w_rd_addr = {~r_slot, r_j - COL_W'(1)};
            3'd2:    w_rd_addr = {~r_slot, r_j + COL_W'(1)};
            3'd3:    w_rd_addr = {r_slot, r_j};
            3'd4:    w_rd_addr = {r_slot, r_j + COL_W'(1)};
            default: w_rd_addr = {r_slot, r_j - COL_W'(1)};
        endcase
    end

    assign w_wr_en = (r_state == ST_READ) && (r_k == 3'd6) && r_dn;

    hvn_mem #(
        .ADDR_W(ADDR_W)
    ) u_mem (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr({r_slot, r_j}),
        .i_wr_data(r_cur),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    // Triangle edge terms. The cross product's vertical part is always one
    // grid cell, so only the two horizontal parts vary; triangles that come
    // out facing down are already flipped here.
    always_comb begin
        case (r_t)
            3'd0: begin
                w_tri_en = r_dn && r_rt;
                w_tx     = -hvn_pkg::hdiff(r_cur, r_h0);
                w_tz     = -hvn_pkg::hdiff(r_hr, r_h0);
            end
            3'd1: begin
                w_tri_en = r_up && r_lf;
                w_tx     = hvn_pkg::hdiff(r_hu, r_h0);
                w_tz     = hvn_pkg::hdiff(r_hl, r_h0);
            end
            3'd2: begin
                w_tri_en = r_dn && r_lf;
                w_tx     = hvn_pkg::hdiff(r_hl, r_hdl);
                w_tz     = hvn_pkg::hdiff(r_hl, r_h0);
            end
            3'd3: begin
                w_tri_en = r_dn && r_lf;
                w_tx     = -hvn_pkg::hdiff(r_cur, r_h0);
                w_tz     = hvn_pkg::hdiff(r_hdl, r_cur);
            end
            3'd4: begin
                w_tri_en = r_up && r_rt;
                w_tx     = hvn_pkg::hdiff(r_hu, r_h0);
                w_tz     = -hvn_pkg::hdiff(r_hr, r_h0);
            end
            default: begin
                w_tri_en = r_up && r_rt;
                w_tx     = hvn_pkg::hdiff(r_hu, r_h0);
                w_tz     = hvn_pkg::hdiff(r_hu, r_hur);
            end
        endcase
    end

    // One shared squarer for the triangle lengths and the final length.
    always_comb begin
        case (r_state)
            ST_SQ:   w_mul_a = (r_k == 3'd0) ? S_W'(r_x) : S_W'(r_z);
            ST_SUM:  w_mul_a = (r_k == 3'd0) ? r_sx : ((r_k == 3'd1) ? r_sy : r_sz);
            default: w_mul_a = '0;
        endcase
    end

    assign w_prod = P_W'(w_mul_a * w_mul_a);

    hvn_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_go_root),
        .i_rad  (r_rad),
        .o_done (w_root_done),
        .o_root (w_root)
    );

    hvn_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_go_div),
        .i_num  (r_dnum),
        .i_den  (DEN_W'(r_root)),
        .o_done (w_div_done),
        .o_quot (w_q)
    );

    assign w_qs   = S_W'(w_q);
    assign w_load = (r_state == ST_OUT) && (!r_ovalid || m_axis_tready);

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_t       = r_t;
        n_x       = r_x;
        n_z       = r_z;
        n_acc     = r_acc;
        n_rad     = r_rad;
        n_root    = r_root;
        n_dnum    = r_dnum;
        n_sx      = r_sx;
        n_sy      = r_sy;
        n_sz      = r_sz;
        n_nx      = r_nx;
        n_ny      = r_ny;
        n_nz      = r_nz;
        n_go_root = 1'b0;
        n_go_div  = 1'b0;
        n_ovalid  = r_ovalid && !m_axis_tready;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_READ;
                    n_k     = '0;
                end
            end
            ST_READ: begin
                if (r_k == 3'd6) begin
                    n_state = r_emit ? ST_TRI : ST_IDLE;
                    n_t     = '0;
                    n_sx    = '0;
                    n_sy    = '0;
                    n_sz    = '0;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            ST_TRI: begin
                if (w_tri_en) begin
                    n_x     = w_tx;
                    n_z     = w_tz;
                    n_k     = '0;
                    n_state = ST_SQ;
                end else if (r_t == LAST_TRI) begin
                    n_k     = '0;
                    n_state = ST_SUM;
                end else begin
                    n_t = r_t + 3'd1;
                end
            end
            ST_SQ: begin
                case (r_k)
                    3'd0: begin
                        n_acc = A_W'(w_prod);
                        n_k   = 3'd1;
                    end
                    3'd1: begin
                        n_acc = r_acc + A_W'(w_prod) + A_W'(65536);
                        n_k   = 3'd2;
                    end
                    default: begin
                        n_rad     = r_acc << 24;
                        n_go_root = 1'b1;
                        n_state   = ST_ROOT;
                    end
                endcase
            end
            ST_ROOT: begin
                if (w_root_done) begin
                    n_root   = w_root;
                    n_dnum   = NUM_W'(r_x) <<< 36;
                    n_go_div = 1'b1;
                    n_k      = '0;
                    n_state  = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    case (r_k)
                        3'd0: begin
                            n_sx     = r_sx + w_qs;
                            n_dnum   = NUM_W'(256) <<< 36;
                            n_go_div = 1'b1;
                            n_k      = 3'd1;
                        end
                        3'd1: begin
                            n_sy     = r_sy + w_qs;
                            n_dnum   = NUM_W'(r_z) <<< 36;
                            n_go_div = 1'b1;
                            n_k      = 3'd2;
                        end
                        default: begin
                            n_sz = r_sz + w_qs;
                            n_k  = '0;
                            if (r_t == LAST_TRI) begin
                                n_state = ST_SUM;
                            end else begin
                                n_t     = r_t + 3'd1;
                                n_state = ST_TRI;
                            end
                        end
                    endcase
                end
            end
            ST_SUM: begin
                case (r_k)
                    3'd0: begin
                        n_acc = A_W'(w_prod);
                        n_k   = 3'd1;
                    end
                    3'd1, 3'd2: begin
                        n_acc = r_acc + A_W'(w_prod);
                        n_k   = r_k + 3'd1;
                    end
                    default: begin
                        n_rad     = r_acc << 6;
                        n_go_root = 1'b1;
                        n_state   = ST_ROOT2;
                    end
                endcase
            end
            ST_ROOT2: begin
                if (w_root_done) begin
                    n_root   = w_root;
                    n_dnum   = NUM_W'(r_sx) <<< 17;
                    n_go_div = 1'b1;
                    n_k      = '0;
                    n_state  = ST_NDIV;
                end
            end
            ST_NDIV: begin
                if (w_div_done) begin
                    case (r_k)
                        3'd0: begin
                            n_nx     = clamp_s(w_q);
                            n_dnum   = NUM_W'(r_sy) <<< 17;
                            n_go_div = 1'b1;
                            n_k      = 3'd1;
                        end
                        3'd1: begin
                            n_ny     = clamp_y(w_q);
                            n_dnum   = NUM_W'(r_sz) <<< 17;
                            n_go_div = 1'b1;
                            n_k      = 3'd2;
                        end
                        default: begin
                            n_nz    = clamp_s(w_q);
                            n_state = ST_OUT;
                        end
                    endcase
                end
            end
            ST_OUT: begin
                if (w_load) begin
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs      <= hvn_pkg::GS_RESET;
            r_col     <= '0;
            r_row     <= '0;
            r_state   <= ST_IDLE;
            r_k       <= '0;
            r_t       <= '0;
            r_go_root <= 1'b0;
            r_go_div  <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_gs <= i_cfg_data;
            end
            r_col     <= n_col;
            r_row     <= n_row;
            r_state   <= n_state;
            r_k       <= n_k;
            r_t       <= n_t;
            r_go_root <= n_go_root;
            r_go_div  <= n_go_div;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cur  <= s_axis_tdata;
            r_j    <= r_col;
            r_slot <= r_row[0];
            r_emit <= (r_row != '0);
            r_up   <= (r_row >= ROW_W'(2));
            r_dn   <= (r_row < w_n);
            r_lf   <= (r_col != '0);
            r_rt   <= (w_col_inc < w_n);
            r_last <= (r_row == w_n) && (w_col_inc == w_n);
        end
        if (r_state == ST_READ) begin
            case (r_k)
                3'd1:    r_h0  <= w_rd_data;
                3'd2:    r_hl  <= w_rd_data;
                3'd3:    r_hr  <= w_rd_data;
                3'd4:    r_hu  <= w_rd_data;
                3'd5:    r_hur <= w_rd_data;
                3'd6:    r_hdl <= w_rd_data;
                default: r_h0  <= r_h0;
            endcase
        end
        r_x    <= n_x;
        r_z    <= n_z;
        r_acc  <= n_acc;
        r_rad  <= n_rad;
        r_root <= n_root;
        r_dnum <= n_dnum;
        r_sx   <= n_sx;
        r_sy   <= n_sy;
        r_sz   <= n_sz;
        r_nx   <= n_nx;
        r_ny   <= n_ny;
        r_nz   <= n_nz;
        if (w_load) begin
            r_onx   <= r_nx;
            r_ony   <= r_ny;
            r_onz   <= r_nz;
            r_olast <= r_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_onz, r_ony, r_onx};
    assign m_axis_tlast  = r_olast;

`ifndef SYNTH
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_root_done && w_div_done))
        else $error("square root and divider finished in the same cycle");

    a_root_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_done |-> (r_state == ST_ROOT || r_state == ST_ROOT2))
        else $error("square root result arrived outside a root state");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV || r_state == ST_NDIV))
        else $error("divider result arrived outside a divide state");

    a_col_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (ROW_W'(r_col) < w_n && r_row <= w_n))
        else $error("grid position left the grid");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> m_axis_tvalid)
        else $error("finished normal was not presented");
`endif

endmodule

// ----- sim/heightmap_vertex_normals_tb.sv -----
`default_nettype none

module heightmap_vertex_normals_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Waiting this long after the last normal outlasts the slowest item (an
    // interior vertex), so it leaves the block surely idle.
    localparam int SETTLE_CYCLES = 1000;
    // Cycles with no request taken on any channel before the run gives up.
    // This covers the long receiver hold-off, the longest sender gap and the
    // block's own item time, several times over.
    localparam int STALL_LIMIT = 30000;
    localparam int HOLD_OFF_CYCLES = 4000;
    localparam int GRID_CAP = hvn_pkg::MAX_GRID_DEF;

    typedef struct packed {
        logic signed [15:0] nx;
        logic [14:0]        ny;
        logic signed [15:0] nz;
        logic               last;
    } t_normal;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data = '0;

    heightmap_vertex_normals dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: the grid size register, the two row slots of heights
    // and the row and column counters, all as the block holds them.
    logic [10:0] grid_reg;
    logic [15:0] row_heights [2*GRID_CAP];
    int unsigned col_pos;
    int unsigned row_pos;

    t_normal pending_normals[$];
    int      error_count = 0;
    int      items_sent = 0;
    bit      hold_off_req = 1'b0;

    // ---------------------------------------------------------------------
    // Fixed-point arithmetic of the normal computation.
    // ---------------------------------------------------------------------

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Division rounded to nearest with halves away from zero.
    function automatic longint div_round(input longint num, input longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Adds the Q.24 unit normal of the triangle spanned by edge vectors a and
    // b, turned to point up, to the running sum.
    task automatic add_face(inout longint acc[3], input int ai, input longint ah,
                            input int aj, input int bi, input longint bh,
                            input int bj);
        longint x;
        longint y;
        longint z;
        longint unsigned len2;
        longint unsigned root;
        x = ah * bj - longint'(aj) * bh;
        y = longint'(aj) * bi - longint'(ai) * bj;
        z = longint'(ai) * bh - ah * bi;
        if (y < 0) begin
            x = -x;
            z = -z;
        end
        len2 = longint'(x * x) + longint'(z * z) + 65536;
        root = int_sqrt(len2 << 24);
        acc[0] += div_round(x * (64'sd1 <<< 36), root);
        acc[1] += div_round(64'sd256 * (64'sd1 <<< 36), root);
        acc[2] += div_round(z * (64'sd1 <<< 36), root);
    endtask

    // Takes one accepted height and, from the second row on, queues the normal
    // of the vertex one row above it.
    task automatic predict_normal(input logic [15:0] height);
        int unsigned n;
        int unsigned r;
        int unsigned c;
        int unsigned slot_cur;
        int unsigned slot_prev;
        int unsigned i;
        int unsigned j;
        bit up;
        bit dn;
        bit lf;
        bit rt;
        longint h0;
        longint hl;
        longint hr;
        longint hu;
        longint hur;
        longint hdl;
        longint hd;
        longint acc[3];
        longint unsigned mag2;
        longint unsigned root;
        t_normal nv;
        n = (grid_reg < 2) ? 2 : ((grid_reg > GRID_CAP) ? GRID_CAP : grid_reg);
        r = row_pos;
        c = col_pos;
        slot_cur = (r & 1) * GRID_CAP;
        slot_prev = ((r + 1) & 1) * GRID_CAP;
        if (r >= 1) begin
            i = r - 1;
            j = c;
            up = i > 0;
            dn = i < n - 1;
            lf = j > 0;
            rt = j < n - 1;
            h0 = row_heights[slot_prev + j];
            hl = lf ? row_heights[slot_prev + j - 1] : 0;
            hr = rt ? row_heights[slot_prev + j + 1] : 0;
            hu = up ? row_heights[slot_cur + j] : 0;
            hur = (up && rt) ? row_heights[slot_cur + j + 1] : 0;
            hdl = (dn && lf) ? row_heights[slot_cur + j - 1] : 0;
            hd = dn ? longint'(height) : 0;
            acc = '{0, 0, 0};
            if (dn && rt)
                add_face(acc, 0, hr - h0, 1, 1, hd - h0, 0);
            if (up && lf)
                add_face(acc, 0, hl - h0, -1, -1, hu - h0, 0);
            if (dn && lf) begin
                add_face(acc, 0, hl - h0, -1, 1, hdl - h0, -1);
                add_face(acc, 1, hdl - h0, -1, 1, hd - h0, 0);
            end
            if (up && rt) begin
                add_face(acc, -1, hu - h0, 0, 0, hr - h0, 1);
                add_face(acc, -1, hu - h0, 0, -1, hur - h0, 1);
            end
            mag2 = longint'(acc[0] * acc[0]) + longint'(acc[1] * acc[1]) +
                   longint'(acc[2] * acc[2]);
            root = int_sqrt(mag2 << 6);
            nv.nx = 16'(clip(div_round(acc[0] * (64'sd1 <<< 17), root), -16384, 16384));
            nv.ny = 15'(clip(div_round(acc[1] * (64'sd1 <<< 17), root), 0, 16384));
            nv.nz = 16'(clip(div_round(acc[2] * (64'sd1 <<< 17), root), -16384, 16384));
            nv.last = (r == n) && (c == n - 1);
            pending_normals = {pending_normals, nv};
        end
        if (r < n)
            row_heights[slot_cur + c] = height;
        c++;
        if (c >= n) begin
            c = 0;
            r++;
            if (r > n)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    // ---------------------------------------------------------------------
    // Drivers.
    // ---------------------------------------------------------------------

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(3, 1);
        else if (roll < 98)
            return $urandom_range(20, 4);
        else
            return $urandom_range(150, 50);
    endfunction

    // Offers one height and returns at the edge that takes the request. The
    // valid stays high on return, so a caller must end a burst with
    // stop_heights or send the next item right away.
    task automatic send_height(input logic [15:0] height, input bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= height;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_normal(height);
        items_sent++;
    endtask

    task automatic stop_heights();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every queued normal has come out and the block has had
    // time to finish any item that yields nothing.
    task automatic wait_idle();
        while (pending_normals.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes grid_size; the predictor restarts its counters just as the
    // block does.
    task automatic write_grid_size(input logic [10:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        grid_reg = value;
        col_pos = 0;
        row_pos = 0;
    endtask

    function automatic int eff_size();
        return (grid_reg < 2) ? 2 : ((grid_reg > GRID_CAP) ? GRID_CAP : grid_reg);
    endfunction

    // Heights for one sample: the kind picks fully random values, a smooth
    // surface, or the two rails of the height range.
    function automatic logic [15:0] make_height(input int kind, input int base);
        case (kind)
            0: return 16'($urandom);
            1: return 16'(base + $urandom_range(1023) - 512);
            default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    // Sends a whole grid, padding row included, with content of one kind.
    task automatic send_grid(input int kind, input bit no_gap = 1'b0);
        int total;
        int base;
        base = $urandom_range(60000, 2000);
        total = eff_size() * (eff_size() + 1);
        repeat (total) send_height(make_height(kind, base), no_gap);
        stop_heights();
    endtask

    // ---------------------------------------------------------------------
    // Checker and receiver stalls.
    // ---------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    initial begin : normal_checker
        t_normal want;
        logic signed [15:0] got_x;
        logic [14:0] got_y;
        logic signed [15:0] got_z;
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got_x = m_axis_tdata[15:0];
                got_y = m_axis_tdata[30:16];
                got_z = m_axis_tdata[46:31];
                if (pending_normals.size() == 0) begin
                    report_mismatch("unexpected normal, x", got_x, 0);
                end else begin
                    want = pending_normals.pop_front();
                    if (got_x !== want.nx)
                        report_mismatch("normal_x", got_x, want.nx);
                    if (got_y !== want.ny)
                        report_mismatch("normal_y", got_y, want.ny);
                    if (got_z !== want.nz)
                        report_mismatch("normal_z", got_z, want.nz);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last", m_axis_tlast, want.last);
                    if (m_axis_tdata[47] !== 1'b0)
                        report_mismatch("tdata pad bit", m_axis_tdata[47], 0);
                end
            end
            // The receiver idles in gaps of random length; a hold-off request
            // from a test forces one long stretch.
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold = HOLD_OFF_CYCLES;
            end else if (hold == 0 && $urandom_range(99) < 30) begin
                hold = pick_gap();
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: counts cycles in which no request is taken anywhere.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("heightmap_vertex_normals regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Tests.
    // ---------------------------------------------------------------------

    // Reset size of 64: one full first row, which yields nothing, then a few
    // normals of the top row before the grid is cut short.
    task automatic test_reset_size();
        repeat (64 + 5) send_height(16'($urandom));
        stop_heights();
    endtask

    // Smallest grid with the height rails: flat low, then a checkerboard of both rails.
    task automatic test_min_grid();
        write_grid_size(11'd2);
        send_height(16'h0000); send_height(16'h0000);
        send_height(16'h0000); send_height(16'h0000);
        send_height(16'h1234); send_height(16'h4321);
        send_height(16'hFFFF); send_height(16'h0000);
        send_height(16'h0000); send_height(16'hFFFF);
        send_height(16'h0000); send_height(16'h0000);
        stop_heights();
    endtask

    // Three by three checkerboard of the rails: every triangle case of an
    // interior vertex sees the steepest slopes of both signs.
    task automatic test_steep_checkerboard();
        write_grid_size(11'd3);
        for (int k = 0; k < 12; k++)
            send_height(((k % 2) == 0) ? 16'hFFFF : 16'h0000);
        stop_heights();
    endtask

    // Sizes outside the range: zero and one act as two, all ones acts as the
    // largest grid, of which one row and a little more is sent.
    task automatic test_size_clamp();
        write_grid_size(11'd0);
        send_grid(0);
        write_grid_size(11'd1);
        send_grid(2);
        write_grid_size(11'h7FF);
        repeat (GRID_CAP + 4) send_height(16'($urandom));
        stop_heights();
    endtask

    // The receiver holds off for a long stretch while heights keep coming,
    // so the output register fills and the input stalls.
    task automatic test_output_backpressure();
        write_grid_size(11'd5);
        hold_off_req = 1'b1;
        send_grid(0, 1'b1);
    endtask

    // Random grids, mostly small, some cut short by a new size.
    task automatic test_random_grids(input int target);
        int size;
        int kind;
        while (items_sent < target) begin
            size = ($urandom_range(9) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 2);
            kind = $urandom_range(9) < 5 ? 0 : ($urandom_range(1) ? 1 : 2);
            write_grid_size(11'(size));
            if ($urandom_range(7) == 0) begin
                repeat ($urandom_range(size * (size + 1) - 1, 1))
                    send_height(make_height(kind, 30000));
                stop_heights();
            end else begin
                send_grid(kind);
            end
        end
    endtask

    initial begin
        grid_reg = hvn_pkg::GS_RESET;
        col_pos = 0;
        row_pos = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_size();
        test_min_grid();
        test_steep_checkerboard();
        test_size_clamp();
        test_output_backpressure();
        test_random_grids(1550);

        wait_idle();
        if (error_count == 0) begin
            $display("heightmap_vertex_normals regression: pass");
        end else begin
            $display("heightmap_vertex_normals regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
sv/hvn_pkg.sv
sv/hvn_mem.sv
sv/hvn_isqrt.sv
sv/hvn_div.sv
sv/heightmap_vertex_normals.sv
sim/heightmap_vertex_normals_tb.sv
